// ===== rtl/core/cvc_pkg.sv =====
// Shared constants, types and register indexes for the compass vector conditioner.
package cvc_pkg;

    // Pipeline depth: offset/abs, scale multiply, clamp+FIR, square+position multiply,
    // reciprocal multiply, merge/output register.
    localparam int NUM_STAGES      = 6;
    localparam int SCREEN_SIZE_DEF = 128;

    localparam int SAMPLE_W = 16;
    localparam int FILT_W   = 10;
    localparam int SQ_W     = 18;
    localparam int MAG_W    = 19;
    localparam int POS8_W   = 8;

    localparam int FIELD_MAX = 450;

    // floor(n * 1024 / 7004) == (n * SCALE_M) >> SCALE_SHIFT, exact for n <= 32768
    localparam int          SCALE_W     = 23;
    localparam logic [22:0] SCALE_M     = 23'd4905731;
    localparam int          SCALE_SHIFT = 25;
    localparam int          SCALE_PW    = SAMPLE_W + SCALE_W;

    // floor(a / 900) == (a * DIV_M) >> DIV_SHIFT, exact for a < 2^20
    localparam int          DIV_W     = 21;
    localparam logic [20:0] DIV_M     = 21'd1193047;
    localparam int          DIV_SHIFT = 30;

    localparam int COL_SHIFT = 6;
    localparam int ROW_SHIFT = 12;

    localparam logic [MAG_W-1:0] LIMIT_SQ = 19'd202500;

    // Configuration register indexes
    localparam logic CFG_X_OFFSET = 1'b0;
    localparam logic CFG_Y_OFFSET = 1'b1;

    localparam int OUT_BITS = 2*FILT_W + MAG_W + 2 + 4*POS8_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;     // stage register enables
        logic                  hist_we;  // valid word enters the FIR stage
        logic                  pos_we;   // valid word enters the output register
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [FILT_W-1:0] filt;
        logic [SQ_W-1:0]          sq;
        logic [POS8_W-1:0]        pos;
    } t_lane_out;

endpackage

// ===== rtl/core/cvc_lane.sv =====
// One axis lane: offset, scale to milligauss, clamp, 1-2-1 FIR, square and screen position.
module cvc_lane
    import cvc_pkg::*;
#(
    parameter int SCREEN_SIZE = SCREEN_SIZE_DEF,
    parameter bit FLIP        = 1'b0,
    parameter int POS_SHIFT   = COL_SHIFT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_pipe_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic signed [SAMPLE_W-1:0]  i_offset,
    output t_lane_out                   o_lane
);

    localparam int POS_W = FILT_W + $clog2(SCREEN_SIZE);
    localparam int PQ_W  = POS_W + DIV_W;
    localparam int QW    = PQ_W - DIV_SHIFT;

    // stage 1: offset and magnitude
    logic signed [SAMPLE_W-1:0] s_diff;
    logic [SAMPLE_W-1:0]        s_abs;
    logic [SAMPLE_W-1:0]        r_abs;
    logic                       r_neg1;

    always_comb begin
        s_diff = i_sample - i_offset;
        s_abs  = s_diff[SAMPLE_W-1] ? SAMPLE_W'(-s_diff) : SAMPLE_W'(s_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_abs  <= s_abs;
            r_neg1 <= s_diff[SAMPLE_W-1];
        end
    end

    // stage 2: scale multiply
    logic [SCALE_PW-1:0] r_prod;
    logic                r_neg2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_prod <= SCALE_PW'(r_abs) * SCALE_PW'(SCALE_M);
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: clamp, restore sign, FIR
    logic [SCALE_PW-SCALE_SHIFT-1:0] s_q;
    logic [8:0]                      s_mag;
    logic signed [FILT_W-1:0]        s_cx;
    logic signed [11:0]              s_sum;
    logic signed [11:0]              s_adj;
    logic signed [FILT_W-1:0]        r_h1;
    logic signed [FILT_W-1:0]        r_h2;
    logic signed [FILT_W-1:0]        r_fx3;

    always_comb begin
        s_q   = r_prod[SCALE_PW-1:SCALE_SHIFT];
        s_mag = (s_q > (SCALE_PW-SCALE_SHIFT)'(FIELD_MAX)) ? 9'(FIELD_MAX) : s_q[8:0];
        s_cx  = r_neg2 ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        s_sum = 12'(r_h2) + (12'(r_h1) <<< 1) + 12'(s_cx);
        // truncate toward zero: bias negative sums by 3 before the shift
        s_adj = s_sum + $signed({10'd0, {2{s_sum[11]}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= '0;
            r_h2 <= '0;
        end else if (i_ctl.hist_we) begin
            r_h1 <= s_cx;
            r_h2 <= r_h1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_fx3 <= s_adj[11:2];
        end
    end

    // stage 4: square and screen-span multiply
    logic signed [10:0]       s_span;
    logic signed [19:0]       s_sq_full;
    logic [POS_W-1:0]         r_pos;
    logic [SQ_W-1:0]          r_sq4;
    logic signed [FILT_W-1:0] r_fx4;

    always_comb begin
        if (FLIP) begin
            s_span = 11'(FIELD_MAX) - 11'(r_fx3);
        end else begin
            s_span = 11'(r_fx3) + 11'(FIELD_MAX);
        end
        s_sq_full = r_fx3 * r_fx3;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_pos <= POS_W'(s_span[9:0]) * POS_W'(SCREEN_SIZE - 1);
            r_sq4 <= s_sq_full[SQ_W-1:0];
            r_fx4 <= r_fx3;
        end
    end

    // stage 5: divide by 900 through the reciprocal
    logic [PQ_W-1:0]          r_pq;
    logic [SQ_W-1:0]          r_sq5;
    logic signed [FILT_W-1:0] r_fx5;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_pq  <= PQ_W'(r_pos) * PQ_W'(DIV_M);
            r_sq5 <= r_sq4;
            r_fx5 <= r_fx4;
        end
    end

    logic [QW-1:0] s_cell;
    logic [15:0]   s_coord;

    always_comb begin
        s_cell  = r_pq[PQ_W-1:DIV_SHIFT];
        s_coord = 16'(s_cell) - 16'(POS_SHIFT);
        o_lane.filt = r_fx5;
        o_lane.sq   = r_sq5;
        o_lane.pos  = s_coord[POS8_W-1:0];
    end

endmodule

// ===== rtl/core/cvc_merge.sv =====
// Merge stage: magnitude, range check, redraw decision and the output register.
module cvc_merge
    import cvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  t_lane_out         i_lane_x,
    input  t_lane_out         i_lane_y,
    output logic [OUT_W-1:0]  o_tdata
);

    logic [MAG_W-1:0]  s_mag;
    logic              s_in_range;
    logic              s_redraw;
    logic [POS8_W-1:0] s_erase_x;
    logic [POS8_W-1:0] s_erase_y;
    logic [POS8_W-1:0] r_prev_col;
    logic [POS8_W-1:0] r_prev_row;
    logic [OUT_W-1:0]  r_tdata;

    always_comb begin
        s_mag      = MAG_W'(i_lane_x.sq) + MAG_W'(i_lane_y.sq);
        s_in_range = s_mag < LIMIT_SQ;
        s_redraw   = s_in_range &&
                     ((i_lane_x.pos != r_prev_col) || (i_lane_y.pos != r_prev_row));
        s_erase_x  = s_redraw ? r_prev_col : '0;
        s_erase_y  = s_redraw ? r_prev_row : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_col <= '0;
            r_prev_row <= '0;
        end else if (i_ctl.pos_we && s_redraw) begin
            r_prev_col <= i_lane_x.pos;
            r_prev_row <= i_lane_y.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[NUM_STAGES-1]) begin
            r_tdata <= OUT_W'({s_erase_y, s_erase_x, i_lane_y.pos, i_lane_x.pos,
                               s_redraw, s_in_range, s_mag,
                               i_lane_y.filt, i_lane_x.filt});
        end
    end

    assign o_tdata = r_tdata;

endmodule

// ===== rtl/core/compass_vector_conditioner.sv =====
// An accepted word passes through every stage in turn; the last stage drives the master side.
// Throughput: one word per cycle; each stage holds one word and advances into a free slot,
// so bubbles collapse and the input keeps accepting while the output register waits,
// until all six stages hold a word; then the input stalls with the output.
// Stage count is set by the two multiply-by-reciprocal divisions (by 7004 and by 900).
// Reset (synchronous, active low) clears offsets, FIR history, the stored marker position
// and all stage valid flags; the pipeline payload is not cleared.
module compass_vector_conditioner
    import cvc_pkg::*;
#(
    parameter int SCREEN_SIZE = SCREEN_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [SAMPLE_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // tdata: [15:0] x_sample, [31:16] y_sample
    input  logic [31:0]         i_s_axis_tdata,
    // output stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata: [9:0] filtered_x, [19:10] filtered_y, [38:20] magnitude_sq, [39] in_range,
    // [40] redraw, [48:41] draw_x, [56:49] draw_y, [64:57] erase_x, [72:65] erase_y,
    // [79:73] zero
    output logic [OUT_W-1:0]    o_m_axis_tdata
);

    // Offset registers; the user must write them only while the pipeline is idle (not enforced here)
    logic signed [SAMPLE_W-1:0] r_x_off;
    logic signed [SAMPLE_W-1:0] r_y_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_off <= '0;
            r_y_off <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_OFFSET: r_x_off <= i_cfg_wdata;
                CFG_Y_OFFSET: r_y_off <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valid flags; the last one is the output register's valid.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] s_en;
    t_pipe_ctl             s_ctl;

    // A stage takes a new word when it is empty or the stage after it advances.
    always_comb begin
        s_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            s_en[k] = !r_vld[k] || s_en[k+1];
        end
        s_ctl.load    = s_en;
        // commit state only when a real word moves into the stage that owns it
        s_ctl.hist_we = s_en[2] && r_vld[1];
        s_ctl.pos_we  = s_en[NUM_STAGES-1] && r_vld[NUM_STAGES-2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (s_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (s_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = s_en[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];

    // Two axis lanes run side by side; Y is flipped for screen rows.
    t_lane_out s_lane_x;
    t_lane_out s_lane_y;

    cvc_lane #(
        .SCREEN_SIZE (SCREEN_SIZE),
        .FLIP        (1'b0),
        .POS_SHIFT   (COL_SHIFT)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_sample (i_s_axis_tdata[15:0]),
        .i_offset (r_x_off),
        .o_lane   (s_lane_x)
    );

    cvc_lane #(
        .SCREEN_SIZE (SCREEN_SIZE),
        .FLIP        (1'b1),
        .POS_SHIFT   (ROW_SHIFT)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_sample (i_s_axis_tdata[31:16]),
        .i_offset (r_y_off),
        .o_lane   (s_lane_y)
    );

    // Combine lanes: magnitude, range, redraw and the stored marker position.
    cvc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (s_ctl),
        .i_lane_x (s_lane_x),
        .i_lane_y (s_lane_y),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule
